[design/ptm_pkg.sv]
// Shared types, constants and helper functions for the parameter taper mapper.
`timescale 1ns / 1ps
`default_nettype none

package ptm_pkg;

    // Fixed-point format of values; proportions are always Q1.16
    localparam int FRAC_BITS = 16;

    localparam int VAL_W     = 32;
    localparam int PROP_W    = 17;
    localparam int LG_W      = 21;   // log2 result: 5 integer bits, 16 fraction bits
    localparam int LG_LAT    = 17;   // normalize stage plus one stage per log2 fraction bit
    localparam int EX_STEPS  = 16;   // one stage per exponent fraction bit
    localparam int DIV_BITS  = 17;   // quotient bits of the proportion divider
    localparam int NUM_W     = 50;
    localparam int DEN_W     = 33;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [PROP_W-1:0] PROP_ONE  = 17'd65536;
    localparam logic [PROP_W-1:0] PROP_HALF = 17'd32768;

    localparam logic signed [VAL_W-1:0] RESET_HIGH = 32'(1 << FRAC_BITS);
    localparam logic [30:0]             RESET_STEP = 31'((1 << FRAC_BITS) / 100);

    localparam logic MODE_VALUE = 1'b0;
    localparam logic MODE_PROP  = 1'b1;

    // Register indexes of the write port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_LOW  = 3'd0,
        REG_RANGE_HIGH = 3'd1,
        REG_STEP       = 3'd2,
        REG_ZERO_THR   = 3'd3,
        REG_TAPER      = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        TAPER_LIN = 2'd0,
        TAPER_EXP = 2'd1,
        TAPER_BIP = 2'd2
    } taper_t;

    typedef struct packed {
        logic                    mode;
        logic signed [VAL_W-1:0] operand;
    } in_word_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] param_value;
        logic [PROP_W-1:0]       proportion;
    } out_word_t;

    // Effective configuration, derived from the registers
    typedef struct packed {
        taper_t                  kind;
        logic signed [VAL_W-1:0] lo;
        logic signed [VAL_W-1:0] hi;
        logic signed [VAL_W-1:0] amin;
        logic signed [VAL_W-1:0] bmax;
        logic [30:0]             zt;
        logic                    flip;
        logic                    bad;   // exponential or bipolar taper with a non-positive bound
    } cfg_t;

    // Word passed from front to back
    typedef struct packed {
        logic signed [VAL_W-1:0] v;
        logic [LG_W-1:0]         lglo;
        logic [LG_W-1:0]         lghi;
    } qword_t;

    // Floor square root, used only at elaboration for the factor table
    function automatic logic [63:0] isqrt64(input logic [63:0] a_in);
        logic [63:0] a;
        logic [63:0] res;
        logic [63:0] bt;
        a   = a_in;
        res = '0;
        bt  = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (a >= res + bt) begin
                a   = a - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // Factors 2^(2^-k), k = 1..16, in Q1.30
    function automatic logic [EX_STEPS-1:0][30:0] exp_factors();
        logic [EX_STEPS-1:0][30:0] f;
        logic [63:0]               t;
        t = 64'd1 << 31;
        for (int k = 0; k < EX_STEPS; k++) begin
            t    = isqrt64(t << 30);
            f[k] = t[30:0];
        end
        return f;
    endfunction

    localparam logic [EX_STEPS-1:0][30:0] EXP_FACTOR = exp_factors();

    // Divide by 2^16, rounded to nearest, ties away from zero
    function automatic logic signed [50:0] rnd16(input logic signed [50:0] x);
        logic [50:0] mag;
        logic [50:0] q;
        mag = x[50] ? 51'(-x) : 51'(x);
        q   = (mag + 51'd32768) >> 16;
        return x[50] ? -$signed(q) : $signed(q);
    endfunction

    // Clamp a 33-bit value into [a, b]
    function automatic logic signed [31:0] sat_range(input logic signed [32:0] x,
                                                     input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [31:0] r;
        if (x < 33'(a)) r = a;
        else if (x > 33'(b)) r = b;
        else r = x[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[design/parameter_taper_mapper_unit.sv]
// Top level of the parameter taper mapper: configuration registers, front, queue, back.
// Throughput: one word per cycle when nothing stalls; front log2/exp pipelines and
// back log2/divider pipelines each take a new word every cycle unless stalled, and
// the 4-entry queue decouples their stalls.
// Reset: asynchronous active-low rst_n clears all valid bits, the queue and the
// registers to range 0..1.0, step 655, threshold 0, linear taper.
`timescale 1ns / 1ps
`default_nettype none

module parameter_taper_mapper_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire ptm_pkg::in_word_t               in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output ptm_pkg::out_word_t                   out_data,
    input  wire logic                            cfg_we,
    input  wire logic [ptm_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  wire logic [31:0]                     cfg_wdata
);

    logic signed [31:0] range_low_reg;
    logic signed [31:0] range_high_reg;
    logic [30:0]        step_reg;
    logic [30:0]        zero_thr_reg;
    logic [1:0]         taper_reg;

    ptm_pkg::cfg_t      cfg;
    logic               subst;
    ptm_pkg::qword_t    q_din;
    ptm_pkg::qword_t    q_dout;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= '0;
            range_high_reg <= ptm_pkg::RESET_HIGH;
            step_reg       <= ptm_pkg::RESET_STEP;
            zero_thr_reg   <= '0;
            taper_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                ptm_pkg::REG_RANGE_LOW:  range_low_reg  <= cfg_wdata;
                ptm_pkg::REG_RANGE_HIGH: range_high_reg <= cfg_wdata;
                ptm_pkg::REG_STEP:       step_reg       <= cfg_wdata[30:0];
                ptm_pkg::REG_ZERO_THR:   zero_thr_reg   <= cfg_wdata[30:0];
                ptm_pkg::REG_TAPER:      taper_reg      <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Effective bounds; unused taper code behaves as linear
    always_comb
    begin
        if (taper_reg == ptm_pkg::TAPER_EXP) cfg.kind = ptm_pkg::TAPER_EXP;
        else if (taper_reg == ptm_pkg::TAPER_BIP) cfg.kind = ptm_pkg::TAPER_BIP;
        else cfg.kind = ptm_pkg::TAPER_LIN;
        subst    = (cfg.kind != ptm_pkg::TAPER_LIN) && (range_low_reg == 32'sd0);
        cfg.lo   = subst ? $signed({1'b0, step_reg}) : range_low_reg;
        cfg.hi   = range_high_reg;
        cfg.zt   = (subst && zero_thr_reg == '0) ? step_reg : zero_thr_reg;
        cfg.flip = range_low_reg > range_high_reg;
        cfg.amin = (cfg.lo < cfg.hi) ? cfg.lo : cfg.hi;
        cfg.bmax = (cfg.lo < cfg.hi) ? cfg.hi : cfg.lo;
        cfg.bad  = (cfg.kind != ptm_pkg::TAPER_LIN)
                   && (cfg.lo <= 32'sd0 || cfg.hi <= 32'sd0);
    end

    ptm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_push   (q_push),
        .q_full   (q_full),
        .q_data   (q_din)
    );

    ptm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    ptm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_data    (q_dout),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

[design/ptm_log2.sv]
// Pipelined log2 unit: one normalize stage, then one squaring stage per result fraction bit.
`timescale 1ns / 1ps
`default_nettype none

module ptm_log2 (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic signed [31:0]           x,
    output logic [ptm_pkg::LG_W-1:0]          lg
);

    localparam int NS = ptm_pkg::LG_LAT;

    logic [4:0]  n_reg  [NS];
    logic [30:0] m_reg  [NS];
    logic [15:0] fr_reg [NS];

    logic [30:0] m_next  [NS];
    logic [15:0] fr_next [NS];
    logic [30:0] u0;
    logic [4:0]  n0;
    logic [30:0] m0;
    logic [61:0] sq;
    logic [31:0] s2;

    // Normalize: msb index and Q1.30 mantissa, inputs below one count as one
    always_comb
    begin
        u0 = (x < 32'sd1) ? 31'd1 : x[30:0];
        n0 = '0;
        for (int i = 0; i < 31; i++)
        begin
            if (u0[i]) n0 = 5'(i);
        end
        m0 = 31'(u0 << (5'd30 - n0));
    end

    // Squaring steps, one fraction bit each
    always_comb
    begin
        sq = '0;
        s2 = '0;
        m_next[0]  = m0;
        fr_next[0] = '0;
        for (int s = 1; s < NS; s++)
        begin
            sq = 62'(m_reg[s-1]) * 62'(m_reg[s-1]);
            s2 = sq[61:30];
            fr_next[s] = fr_reg[s-1];
            if (s2[31])
            begin
                m_next[s] = s2[31:1];
                fr_next[s][NS-1-s] = 1'b1;
            end
            else
            begin
                m_next[s] = s2[30:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0] <= n0;
            for (int s = 0; s < NS; s++)
            begin
                m_reg[s]  <= m_next[s];
                fr_reg[s] <= fr_next[s];
            end
            for (int s = 1; s < NS; s++)
            begin
                n_reg[s] <= n_reg[s-1];
            end
        end
    end

    assign lg = {n_reg[NS-1], fr_reg[NS-1]};

endmodule

`default_nettype wire

[design/ptm_queue.sv]
// Short FIFO between the front and back parts of the mapper.
`timescale 1ns / 1ps
`default_nettype none

module ptm_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire ptm_pkg::qword_t din,
    input  wire logic            pop,
    output ptm_pkg::qword_t      dout,
    output logic                 full,
    output logic                 empty
);

    ptm_pkg::qword_t             mem_reg [ptm_pkg::QDEPTH];
    logic [ptm_pkg::QPTR_W-1:0]  wr_reg;
    logic [ptm_pkg::QPTR_W-1:0]  rd_reg;
    logic [ptm_pkg::QPTR_W:0]    cnt_reg;
    logic                        do_push;
    logic                        do_pop;

    assign full    = (cnt_reg == (ptm_pkg::QPTR_W+1)'(ptm_pkg::QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push) wr_reg <= wr_reg + 1'b1;
            if (do_pop) rd_reg <= rd_reg + 1'b1;
            if (do_push && !do_pop) cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push) mem_reg[wr_reg] <= din;
    end

endmodule

`default_nettype wire

[design/ptm_front.sv]
// Front part: accepts words, clamps values, and maps proportions to values.
`timescale 1ns / 1ps
`default_nettype none

module ptm_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ptm_pkg::cfg_t     cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ptm_pkg::in_word_t in_data,
    output logic                   q_push,
    input  wire logic              q_full,
    output ptm_pkg::qword_t        q_data
);

    localparam int NS = ptm_pkg::LG_LAT;
    localparam int NX = ptm_pkg::EX_STEPS;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] v0;
        logic [16:0]        p;
        logic [16:0]        pe;
        logic               pos;
    } sb_t;

    typedef struct packed {
        logic                           mode;
        logic signed [31:0]             v0;
        logic                           pos;
        logic [ptm_pkg::LG_W-1:0]       lglo;
        logic [ptm_pkg::LG_W-1:0]       lghi;
        logic signed [39:0]             pexp;
        logic signed [50:0]             plin;
    } mul_t;

    typedef struct packed {
        logic                           mode;
        logic signed [31:0]             v0;
        logic                           pos;
        logic signed [23:0]             e;
        logic signed [33:0]             vlin;
        logic [30:0]                    r;
        logic [ptm_pkg::LG_W-1:0]       lglo;
        logic [ptm_pkg::LG_W-1:0]       lghi;
    } ex_t;

    logic                     en;
    sb_t                      sb_reg  [NS];
    logic [NS-1:0]            sbv_reg;
    mul_t                     mul_reg;
    logic                     mulv_reg;
    ex_t                      x_reg   [NX+1];
    logic [NX:0]              xv_reg;

    sb_t                      sb_in;
    mul_t                     mul_next;
    ex_t                      x_next  [NX+1];
    logic [ptm_pkg::LG_W-1:0] lglo;
    logic [ptm_pkg::LG_W-1:0] lghi;
    logic signed [32:0]       op33;
    logic [16:0]              p_c;
    logic signed [21:0]       dl;
    logic signed [32:0]       span;
    logic [61:0]              prod;
    logic [30:0]              mag;
    logic [4:0]               sh;
    logic signed [31:0]       vexp;
    logic signed [32:0]       av;
    logic signed [31:0]       vout;

    // The whole front stalls while the queue is full
    assign en       = !q_full;
    assign in_ready = en;

    ptm_log2 u_lg_lo (
        .clk (clk),
        .en  (en),
        .x   (cfg.lo),
        .lg  (lglo)
    );

    ptm_log2 u_lg_hi (
        .clk (clk),
        .en  (en),
        .x   (cfg.hi),
        .lg  (lghi)
    );

    // Entry: clamp value, clamp and flip proportion, bipolar fold
    always_comb
    begin
        op33        = 33'(in_data.operand);
        sb_in.mode  = in_data.mode;
        if (cfg.kind == ptm_pkg::TAPER_BIP)
        begin
            if (op33 > 33'sd0) sb_in.v0 = ptm_pkg::sat_range(op33, cfg.amin, cfg.bmax);
            else if (op33 < 33'sd0) sb_in.v0 = -ptm_pkg::sat_range(-op33, cfg.amin, cfg.bmax);
            else sb_in.v0 = '0;
        end
        else
        begin
            sb_in.v0 = ptm_pkg::sat_range(op33, cfg.amin, cfg.bmax);
        end
        if (in_data.operand < 32'sd0) p_c = '0;
        else if (in_data.operand > 32'sd65536) p_c = ptm_pkg::PROP_ONE;
        else p_c = in_data.operand[16:0];
        sb_in.p = cfg.flip ? ptm_pkg::PROP_ONE - p_c : p_c;
        if (cfg.kind == ptm_pkg::TAPER_BIP)
        begin
            sb_in.pos = sb_in.p > ptm_pkg::PROP_HALF;
            sb_in.pe  = sb_in.pos ? 17'((sb_in.p - ptm_pkg::PROP_HALF) << 1)
                                  : 17'((ptm_pkg::PROP_HALF - sb_in.p) << 1);
        end
        else
        begin
            sb_in.pos = 1'b1;
            sb_in.pe  = sb_in.p;
        end
    end

    // Products of the proportion with the log span and the linear span
    always_comb
    begin
        dl            = $signed({1'b0, lghi}) - $signed({1'b0, lglo});
        span          = 33'(cfg.hi) - 33'(cfg.lo);
        mul_next.mode = sb_reg[NS-1].mode;
        mul_next.v0   = sb_reg[NS-1].v0;
        mul_next.pos  = sb_reg[NS-1].pos;
        mul_next.lglo = lglo;
        mul_next.lghi = lghi;
        mul_next.pexp = $signed({1'b0, sb_reg[NS-1].pe}) * dl;
        mul_next.plin = $signed({1'b0, sb_reg[NS-1].p}) * span;
    end

    // Exponent, linear value, then one factor per exponent fraction bit
    always_comb
    begin
        prod           = '0;
        x_next[0].mode = mul_reg.mode;
        x_next[0].v0   = mul_reg.v0;
        x_next[0].pos  = mul_reg.pos;
        x_next[0].lglo = mul_reg.lglo;
        x_next[0].lghi = mul_reg.lghi;
        x_next[0].e    = $signed({3'b0, mul_reg.lglo})
                         + 24'(ptm_pkg::rnd16(51'(mul_reg.pexp)));
        x_next[0].vlin = 34'(cfg.lo) + 34'(ptm_pkg::rnd16(mul_reg.plin));
        x_next[0].r    = 31'd1 << 30;
        for (int k = 1; k <= NX; k++)
        begin
            x_next[k] = x_reg[k-1];
            if (x_reg[k-1].e[NX-k])
            begin
                prod = 62'(x_reg[k-1].r) * 62'(ptm_pkg::EXP_FACTOR[k-1]) + (62'd1 << 29);
                x_next[k].r = prod[60:30];
            end
        end
    end

    // Final value: shift by the exponent integer part, snap, select by mode
    always_comb
    begin
        sh = '0;
        if (x_reg[NX].e[23]) mag = '0;
        else if (x_reg[NX].e[23:16] >= 8'd31) mag = 31'h7FFF_FFFF;
        else if (x_reg[NX].e[23:16] == 8'd30) mag = x_reg[NX].r;
        else
        begin
            sh  = 5'(8'd29 - x_reg[NX].e[23:16]);
            mag = 31'((32'(x_reg[NX].r >> sh) + 32'd1) >> 1);
        end
        if (mag < cfg.zt) mag = '0;
        vexp = x_reg[NX].pos ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
        av   = x_reg[NX].v0[31] ? -33'(x_reg[NX].v0) : 33'(x_reg[NX].v0);

        if (x_reg[NX].mode == ptm_pkg::MODE_VALUE)
        begin
            vout = (av <= $signed({2'b0, cfg.zt})) ? '0 : x_reg[NX].v0;
        end
        else if (cfg.kind == ptm_pkg::TAPER_LIN)
        begin
            if (x_reg[NX].vlin > 34'sh0_7FFF_FFFF) vout = 32'sh7FFF_FFFF;
            else if (x_reg[NX].vlin < -34'sh0_8000_0000) vout = 32'sh8000_0000;
            else vout = x_reg[NX].vlin[31:0];
        end
        else if (cfg.bad)
        begin
            vout = '0;
        end
        else
        begin
            vout = vexp;
        end
    end

    assign q_push      = en && xv_reg[NX];
    assign q_data.v    = vout;
    assign q_data.lglo = x_reg[NX].lglo;
    assign q_data.lghi = x_reg[NX].lghi;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sbv_reg  <= '0;
            mulv_reg <= 1'b0;
            xv_reg   <= '0;
        end
        else if (en)
        begin
            sbv_reg  <= {sbv_reg[NS-2:0], in_valid};
            mulv_reg <= sbv_reg[NS-1];
            xv_reg   <= {xv_reg[NX-1:0], mulv_reg};
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= sb_in;
            for (int s = 1; s < NS; s++)
            begin
                sb_reg[s] <= sb_reg[s-1];
            end
            mul_reg <= mul_next;
            for (int k = 0; k <= NX; k++)
            begin
                x_reg[k] <= x_next[k];
            end
        end
    end

endmodule

`default_nettype wire

[design/ptm_back.sv]
// Back part: computes the proportion of each value and holds the output word.
`timescale 1ns / 1ps
`default_nettype none

module ptm_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ptm_pkg::cfg_t  cfg,
    input  wire logic           q_empty,
    output logic                q_pop,
    input  wire ptm_pkg::qword_t q_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ptm_pkg::out_word_t  out_data
);

    localparam int NS = ptm_pkg::LG_LAT;
    localparam int ND = ptm_pkg::DIV_BITS;

    typedef struct packed {
        logic signed [31:0]       v;
        logic [ptm_pkg::LG_W-1:0] lglo;
        logic [ptm_pkg::LG_W-1:0] lghi;
        logic                     pos;
    } sb_t;

    typedef struct packed {
        logic signed [31:0]                 v;
        logic                               pos;
        logic signed [ptm_pkg::NUM_W-1:0]   num;
        logic [ptm_pkg::DEN_W-1:0]          den;
    } d0_t;

    typedef struct packed {
        logic signed [31:0]                 v;
        logic                               pos;
        logic                               neg;
        logic                               zero;
        logic [ptm_pkg::NUM_W-1:0]          nn;
        logic [ptm_pkg::DEN_W-1:0]          den;
    } d1_t;

    typedef struct packed {
        logic signed [31:0]                 v;
        logic                               pos;
        logic                               neg;
        logic                               zero;
        logic                               over;
        logic [ptm_pkg::NUM_W-1:0]          rem;
        logic [ptm_pkg::DEN_W-1:0]          den;
        logic [ND-1:0]                      q;
    } dv_t;

    logic                       en;
    sb_t                        sb_reg [NS];
    logic [NS-1:0]              sbv_reg;
    d0_t                        d0_reg;
    logic                       d0v_reg;
    d1_t                        d1_reg;
    logic                       d1v_reg;
    dv_t                        dv_reg [ND+1];
    logic [ND:0]                dvv_reg;
    logic                       out_valid_reg;
    ptm_pkg::out_word_t         out_data_reg;

    sb_t                        sb_in;
    logic signed [32:0]         v33;
    logic signed [32:0]         mm33;
    logic signed [31:0]         ms;
    logic [ptm_pkg::LG_W-1:0]   lgm;
    d0_t                        d0_next;
    d1_t                        d1_next;
    dv_t                        dv_next [ND+1];
    logic signed [32:0]         diff;
    logic signed [21:0]         ld;
    logic signed [33:0]         den_s;
    logic signed [ptm_pkg::NUM_W-1:0] num_s;
    logic [ptm_pkg::NUM_W-1:0]  trial;
    logic [ptm_pkg::PROP_W-1:0] cap;
    logic [ptm_pkg::PROP_W-1:0] qs;
    logic [ptm_pkg::PROP_W-1:0] tq;
    ptm_pkg::out_word_t         out_next;

    // Output register frees the pipeline when empty or taken
    assign en        = !out_valid_reg || out_ready;
    assign q_pop     = en && !q_empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Entry: magnitude clamp and threshold floor for the log2 input
    always_comb
    begin
        v33        = 33'(q_data.v);
        sb_in.v    = q_data.v;
        sb_in.lglo = q_data.lglo;
        sb_in.lghi = q_data.lghi;
        sb_in.pos  = (cfg.kind == ptm_pkg::TAPER_EXP) || (q_data.v > 32'sd0);
        mm33       = sb_in.pos ? v33 : -v33;
        ms         = ptm_pkg::sat_range(mm33, cfg.amin, cfg.bmax);
        if (ms < $signed({1'b0, cfg.zt})) ms = $signed({1'b0, cfg.zt});
    end

    ptm_log2 u_lg_m (
        .clk (clk),
        .en  (en),
        .x   (ms),
        .lg  (lgm)
    );

    // Numerator and divisor, sign moved onto the numerator
    always_comb
    begin
        diff = 33'(sb_reg[NS-1].v) - 33'(cfg.lo);
        ld   = $signed({1'b0, lgm}) - $signed({1'b0, sb_reg[NS-1].lglo});
        if (cfg.kind == ptm_pkg::TAPER_LIN)
        begin
            num_s = 50'($signed({diff, 16'd0}));
            den_s = 34'(cfg.hi) - 34'(cfg.lo);
        end
        else
        begin
            num_s = (cfg.kind == ptm_pkg::TAPER_BIP) ? 50'($signed({ld, 15'd0}))
                                                   : 50'($signed({ld, 16'd0}));
            den_s = 34'($signed({1'b0, sb_reg[NS-1].lghi})
                        - $signed({1'b0, sb_reg[NS-1].lglo}));
        end
        if (den_s < 34'sd0)
        begin
            num_s = -num_s;
            den_s = -den_s;
        end
        d0_next.v   = sb_reg[NS-1].v;
        d0_next.pos = sb_reg[NS-1].pos;
        d0_next.num = num_s;
        d0_next.den = den_s[32:0];
    end

    // Rounding offset, flags
    always_comb
    begin
        d1_next.v    = d0_reg.v;
        d1_next.pos  = d0_reg.pos;
        d1_next.neg  = d0_reg.num[ptm_pkg::NUM_W-1];
        d1_next.zero = (d0_reg.den == '0);
        d1_next.nn   = ptm_pkg::NUM_W'(d0_reg.num)
                       + ptm_pkg::NUM_W'(d0_reg.den >> 1);
        d1_next.den  = d0_reg.den;
    end

    // Overflow check, then one restoring step per quotient bit
    always_comb
    begin
        trial           = '0;
        dv_next[0].v    = d1_reg.v;
        dv_next[0].pos  = d1_reg.pos;
        dv_next[0].neg  = d1_reg.neg;
        dv_next[0].zero = d1_reg.zero;
        dv_next[0].over = d1_reg.nn >= {d1_reg.den, 17'd0};
        dv_next[0].rem  = d1_reg.nn;
        dv_next[0].den  = d1_reg.den;
        dv_next[0].q    = '0;
        for (int i = 1; i <= ND; i++)
        begin
            dv_next[i] = dv_reg[i-1];
            trial      = ptm_pkg::NUM_W'(dv_reg[i-1].den) << (ND - i);
            if (dv_reg[i-1].rem >= trial)
            begin
                dv_next[i].rem      = dv_reg[i-1].rem - trial;
                dv_next[i].q[ND-i]  = 1'b1;
            end
        end
    end

    // Saturate, bipolar offset, flip, zero for a bad bound
    always_comb
    begin
        cap = (cfg.kind == ptm_pkg::TAPER_BIP) ? ptm_pkg::PROP_HALF : ptm_pkg::PROP_ONE;
        if (dv_reg[ND].zero || dv_reg[ND].neg) qs = '0;
        else if (dv_reg[ND].over || dv_reg[ND].q > cap) qs = cap;
        else qs = dv_reg[ND].q;
        if (cfg.kind == ptm_pkg::TAPER_BIP)
            tq = dv_reg[ND].pos ? ptm_pkg::PROP_HALF + qs : ptm_pkg::PROP_HALF - qs;
        else
            tq = qs;
        if (cfg.flip) tq = ptm_pkg::PROP_ONE - tq;
        if (cfg.kind != ptm_pkg::TAPER_LIN && cfg.bad) tq = '0;
        out_next.param_value = dv_reg[ND].v;
        out_next.proportion  = tq;
    end

    // Valid bits and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sbv_reg       <= '0;
            d0v_reg       <= 1'b0;
            d1v_reg       <= 1'b0;
            dvv_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sbv_reg       <= {sbv_reg[NS-2:0], !q_empty};
            d0v_reg       <= sbv_reg[NS-1];
            d1v_reg       <= d0v_reg;
            dvv_reg       <= {dvv_reg[ND-1:0], d1v_reg};
            out_valid_reg <= dvv_reg[ND];
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= sb_in;
            for (int s = 1; s < NS; s++)
            begin
                sb_reg[s] <= sb_reg[s-1];
            end
            d0_reg <= d0_next;
            d1_reg <= d1_next;
            for (int i = 0; i <= ND; i++)
            begin
                dv_reg[i] <= dv_next[i];
            end
            out_data_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

[tb/taper_checker.sv]
// Watches the mapper's channels, predicts each result word and compares it.
`timescale 1ns / 1ps

module taper_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  ptm_pkg::in_word_t             in_data,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  ptm_pkg::out_word_t            out_data,
    input  logic                          cfg_we,
    input  logic [ptm_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [31:0]                   cfg_wdata,
    output int                            fail_count,
    output int                            outstanding
);

    // Shadow copy of the configuration registers
    longint    shd_low;
    longint    shd_high;
    longint    shd_step;
    longint    shd_zthr;
    logic [1:0] shd_taper;

    ptm_pkg::out_word_t mapped_words[$];

    function automatic longint rnd_div(longint num, longint den);
        if (den == 0) return 0;
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint clampv(longint x, longint a, longint b);
        return x < a ? a : (x > b ? b : x);
    endfunction

    function automatic longint unsigned sqrt_floor(longint unsigned a);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > a) bt = bt >> 2;
        while (bt != 0)
        begin
            if (a >= res + bt)
            begin
                a   = a - (res + bt);
                res = (res >> 1) + bt;
            end
            else
                res = res >> 1;
            bt = bt >> 2;
        end
        return res;
    endfunction

    // log2 in Q.16 by repeated squaring of the normalized mantissa
    function automatic longint log2_q16(longint x);
        longint unsigned u;
        longint unsigned m;
        longint          r;
        int              n;
        u = (x < 1) ? 64'd1 : x;
        n = 0;
        while (n < 62 && (u >> (n + 1)) != 0) n++;
        m = (n <= 30) ? (u << (30 - n)) : (u >> (n - 30));
        r = longint'(n) * 65536;
        for (int i = 15; i >= 0; i--)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                r = r + (longint'(1) << i);
            end
        end
        return r;
    endfunction

    // 2^e, e in Q.16, saturated to 31 bits
    function automatic longint exp2_q16(longint e);
        longint unsigned t;
        longint unsigned r;
        longint unsigned f;
        longint          n;
        longint          v;
        if (e < 0) return 0;
        n = e >>> 16;
        if (n >= 31) return 2147483647;
        t = 64'd2 << 30;
        r = 64'd1 << 30;
        f = e & 64'hFFFF;
        for (int k = 1; k <= 16; k++)
        begin
            t = sqrt_floor(t << 30);
            if ((f >> (16 - k)) & 1) r = (r * t + (64'd1 << 29)) >> 30;
        end
        if (n >= 30) v = longint'(r << (n - 30));
        else v = longint'((r + (64'd1 << (29 - n))) >> (30 - n));
        return v > 2147483647 ? 2147483647 : v;
    endfunction

    function automatic longint prop_of_value(longint v, ptm_pkg::taper_t kind, longint lo,
                                             longint hi, longint zt, bit flip);
        longint a;
        longint b;
        longint q;
        longint m;
        longint dl;
        bit     pos;
        a = lo < hi ? lo : hi;
        b = lo < hi ? hi : lo;
        if (kind == ptm_pkg::TAPER_LIN)
            q = clampv(rnd_div((v - lo) * 65536, hi - lo), 0, 65536);
        else
        begin
            if (lo <= 0 || hi <= 0) return 0;
            pos = (kind == ptm_pkg::TAPER_EXP) || v > 0;
            m = pos ? v : -v;
            m = clampv(m, a, b);
            if (m < zt) m = zt;
            dl = log2_q16(hi) - log2_q16(lo);
            if (kind == ptm_pkg::TAPER_EXP)
                q = clampv(rnd_div((log2_q16(m) - log2_q16(lo)) * 65536, dl), 0, 65536);
            else
            begin
                q = clampv(rnd_div((log2_q16(m) - log2_q16(lo)) * 32768, dl), 0, 32768);
                q = pos ? 32768 + q : 32768 - q;
            end
        end
        return flip ? 65536 - q : q;
    endfunction

    function automatic ptm_pkg::out_word_t map_word(ptm_pkg::in_word_t w);
        ptm_pkg::taper_t    kind;
        longint             lo;
        longint             hi;
        longint             zt;
        longint             a;
        longint             b;
        longint             v;
        longint             p;
        longint             mag;
        longint             e;
        bit                 flip;
        bit                 pos;
        ptm_pkg::out_word_t r;
        kind = (shd_taper > 2) ? ptm_pkg::TAPER_LIN : ptm_pkg::taper_t'(shd_taper);
        lo   = shd_low;
        hi   = shd_high;
        zt   = shd_zthr;
        flip = shd_low > shd_high;
        if (kind != ptm_pkg::TAPER_LIN && lo == 0)
        begin
            lo = shd_step;
            if (zt == 0) zt = shd_step;
        end
        a = lo < hi ? lo : hi;
        b = lo < hi ? hi : lo;
        if (w.mode == ptm_pkg::MODE_VALUE)
        begin
            v = longint'(w.operand);
            if (kind == ptm_pkg::TAPER_BIP)
            begin
                if (v > 0) v = clampv(v, a, b);
                else if (v < 0) v = -clampv(-v, a, b);
            end
            else
                v = clampv(v, a, b);
            if ((v < 0 ? -v : v) <= zt) v = 0;
        end
        else
        begin
            p = clampv(longint'(w.operand), 0, 65536);
            if (flip) p = 65536 - p;
            if (kind == ptm_pkg::TAPER_LIN)
                v = lo + rnd_div(p * (hi - lo), 65536);
            else if (lo <= 0 || hi <= 0)
                v = 0;
            else
            begin
                pos = 1'b1;
                if (kind == ptm_pkg::TAPER_BIP)
                begin
                    pos = p > 32768;
                    p   = pos ? (p - 32768) * 2 : (32768 - p) * 2;
                end
                e   = log2_q16(lo) + rnd_div(p * (log2_q16(hi) - log2_q16(lo)), 65536);
                mag = exp2_q16(e);
                if (mag < zt) mag = 0;
                v = pos ? mag : -mag;
            end
            v = clampv(v, -64'sd2147483648, 64'sd2147483647);
        end
        r.param_value = v[31:0];
        r.proportion  = ptm_pkg::PROP_W'(prop_of_value(v, kind, lo, hi, zt, flip));
        return r;
    endfunction

    // Track writes, predict on input, compare on output
    always @(posedge clk or negedge rst_n)
    begin
        ptm_pkg::out_word_t exp_w;
        int                 errs;
        if (!rst_n)
        begin
            shd_low     <= 0;
            shd_high    <= 65536;
            shd_step    <= 655;
            shd_zthr    <= 0;
            shd_taper   <= ptm_pkg::TAPER_LIN;
            fail_count  <= 0;
            outstanding <= 0;
            mapped_words.delete();
        end
        else
        begin
            errs = 0;
            if (in_valid && in_ready) mapped_words = {mapped_words, map_word(in_data)};
            if (out_valid && out_ready)
            begin
                if (mapped_words.size() == 0)
                begin
                    $error("unexpected result word %h", out_data);
                    errs++;
                end
                else
                begin
                    exp_w = mapped_words.pop_front();
                    if (out_data.param_value !== exp_w.param_value)
                    begin
                        $error("param_value expected %0d actual %0d",
                               exp_w.param_value, out_data.param_value);
                        errs++;
                    end
                    if (out_data.proportion !== exp_w.proportion)
                    begin
                        $error("proportion expected %0d actual %0d",
                               exp_w.proportion, out_data.proportion);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            if (cfg_we)
            begin
                case (cfg_idx)
                    ptm_pkg::REG_RANGE_LOW:  shd_low   <= longint'($signed(cfg_wdata));
                    ptm_pkg::REG_RANGE_HIGH: shd_high  <= longint'($signed(cfg_wdata));
                    ptm_pkg::REG_STEP:       shd_step  <= longint'(cfg_wdata[30:0]);
                    ptm_pkg::REG_ZERO_THR:   shd_zthr  <= longint'(cfg_wdata[30:0]);
                    ptm_pkg::REG_TAPER:      shd_taper <= cfg_wdata[1:0];
                    default: ;
                endcase
            end
            outstanding <= mapped_words.size();
        end
    end

endmodule

[tb/parameter_taper_mapper_unit_tb.sv]
// Top of the mapper testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module parameter_taper_mapper_unit_tb;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    ptm_pkg::in_word_t             in_data = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    ptm_pkg::out_word_t            out_data;
    logic                          cfg_we = 1'b0;
    logic [ptm_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [31:0]                   cfg_wdata = '0;
    int                            fail_count;
    int                            outstanding;

    int snd_idle = 6;
    int rcv_idle = 84;
    int hold_cycles = 0;
    int words_sent = 0;
    int settings_run = 0;

    // Fixed register sets for the first twelve phases
    logic [31:0] set_lo[12] = '{32'd0, 32'hFFFB_0000, 32'd6553600, 32'd0, 32'd6554,
                                32'd65536000, 32'd0, 32'hFFFF_0000, 32'd0, 32'h8000_0000,
                                32'd1, 32'd131072};
    logic [31:0] set_hi[12] = '{32'd65536, 32'd327680, 32'hFF9C_0000, 32'd655360,
                                32'd65536000, 32'd6554, 32'd524288, 32'd524288,
                                32'd65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd131072};
    logic [31:0] set_st[12] = '{32'd655, 32'd655, 32'd1, 32'd655, 32'd100, 32'd655,
                                32'd6553, 32'd655, 32'h7FFF_FFFF, 32'd0, 32'd1, 32'd655};
    logic [31:0] set_zt[12] = '{32'd0, 32'd6554, 32'd65536, 32'd0, 32'd0, 32'd700,
                                32'd0, 32'd100, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0};
    logic [31:0] set_kd[12] = '{ptm_pkg::TAPER_LIN, ptm_pkg::TAPER_LIN, ptm_pkg::TAPER_LIN,
                                ptm_pkg::TAPER_EXP, ptm_pkg::TAPER_EXP, ptm_pkg::TAPER_EXP,
                                ptm_pkg::TAPER_BIP, ptm_pkg::TAPER_BIP, 32'd3,
                                ptm_pkg::TAPER_LIN, ptm_pkg::TAPER_EXP, ptm_pkg::TAPER_EXP};

    parameter_taper_mapper_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    taper_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Receiver: long hold-off when requested, else random stalls
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ready   = 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
            out_ready = ($urandom_range(99) >= rcv_idle);
    end

    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_word(logic mode, logic [31:0] operand);
        while ($urandom_range(99) < snd_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data.mode    = mode;
        in_data.operand = operand;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic write_reg(ptm_pkg::reg_idx_t idx, logic [31:0] val);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Drain, then load a full register set
    task automatic load_setting(logic [31:0] lo, logic [31:0] hi, logic [31:0] step,
                                logic [31:0] zt, logic [31:0] kind);
        in_valid = 1'b0;
        while (outstanding != 0 || out_valid) @(negedge clk);
        repeat (80) @(negedge clk);
        write_reg(ptm_pkg::REG_RANGE_LOW, lo);
        write_reg(ptm_pkg::REG_RANGE_HIGH, hi);
        write_reg(ptm_pkg::REG_STEP, step);
        write_reg(ptm_pkg::REG_ZERO_THR, zt);
        write_reg(ptm_pkg::REG_TAPER, kind);
        settings_run++;
    endtask

    task automatic random_word(logic [31:0] lo, logic [31:0] hi);
        logic [31:0] op;
        logic        mode;
        int          span;
        mode = 1'($urandom_range(1));
        case ($urandom_range(3))
            0: op = $urandom;
            1: op = mode ? 32'($urandom_range(65536)) : lo + $urandom_range(65535);
            2: op = mode ? 32'($urandom_range(65536)) : -$signed(hi) + $urandom_range(4095);
            default:
            begin
                span = $urandom_range(20);
                op   = mode ? 32'($urandom_range(65536)) : $urandom >>> span;
            end
        endcase
        send_word(mode, op);
    endtask

    task automatic directed_words();
        logic [31:0] ops[6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd1,
                                32'hFFFF_FFFF, 32'd32768};
        foreach (ops[i]) send_word(ptm_pkg::MODE_VALUE, ops[i]);
        foreach (ops[i]) send_word(ptm_pkg::MODE_PROP, ops[i]);
        send_word(ptm_pkg::MODE_PROP, 32'd65536);
        send_word(ptm_pkg::MODE_PROP, 32'd70000);
    endtask

    initial
    begin
        logic [31:0] lo;
        logic [31:0] hi;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed words under reset values, then under a bipolar taper
        directed_words();
        load_setting(32'd0, 32'd524288, 32'd6553, 32'd0, ptm_pkg::TAPER_BIP);
        directed_words();

        // Random words over fixed and random settings, three idling regimes
        for (int ph = 0; ph < 18; ph++)
        begin
            if (ph < 6)
            begin
                snd_idle = 6;
                rcv_idle = 84;
            end
            else if (ph < 12)
            begin
                snd_idle = 84;
                rcv_idle = 6;
            end
            else
            begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            if (ph < 12)
            begin
                lo = set_lo[ph];
                hi = set_hi[ph];
                load_setting(lo, hi, set_st[ph], set_zt[ph], set_kd[ph]);
            end
            else
            begin
                lo = ($urandom_range(3) == 0) ? 32'd0 : $urandom >>> $urandom_range(31);
                hi = $urandom >>> $urandom_range(31);
                load_setting(lo, hi, $urandom >> $urandom_range(31),
                             $urandom >> $urandom_range(31), $urandom_range(3));
            end
            if (ph == 14) hold_cycles = 300;
            for (int n = 0; n < 88; n++) random_word(lo, hi);
        end

        in_valid = 1'b0;
        while (outstanding != 0 || out_valid) @(negedge clk);
        repeat (100) @(negedge clk);
        $display("Covered %0d words over %0d register settings, all three tapers,",
                 words_sent, settings_run + 1);
        $display("flipped and degenerate ranges, random stalls and a long output hold-off.");
        if (fail_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
